FILE: rtl/rpt_pkg.sv
package rpt_pkg;

  localparam int MIN_BIN_W  = 5;
  localparam int MAG_CFG_W  = 23;
  localparam int THR_W      = 2 * MAG_CFG_W;
  localparam int PEAK_BIN_W = 5;
  localparam int RD_IDX_W   = 8;
  localparam int PHASE_W    = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAG = 2'd1;

  localparam logic REQ_BIN    = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // vectoring cordic: inputs brought to 40 bits, 24 micro-rotations
  localparam int CORDIC_STEPS    = 24;
  localparam int CORDIC_IT_W     = 5;
  localparam int CORDIC_PRESCALE = 40;
  localparam int CORDIC_W        = 43;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic        done;
    logic [31:0] turns;
  } cordic_stat_t;

endpackage

FILE: rtl/range_peak_phase_tracker.sv
// Channel  Handshake           Payload
// in       in_valid/in_ready   req_type, bin_re, bin_im, last_bin, read_index
// out      out_valid/out_ready kind, target_found, peak_bin, peak_phase,
//                              unwrapped_phase, samples_held, analysis_due, read_data
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// Bins are taken one per cycle while idle. A last bin holds in_ready low through drain,
// check, cordic and finish (the last two with a target) and emit, waiting on out_ready.
// A read item holds in_ready low in S_RDOUT, set by the ring RAM's registered read port.
// Results wait in one output register; bins keep flowing while it is full.
// Reset is synchronous; no clearing pass, unwritten ring slots read as zero
// by comparing against the fill count.
module range_peak_phase_tracker #(
  parameter int NUM_BINS    = 32,
  parameter int RING_DEPTH  = 256,
  parameter int SAMPLE_BITS = 24,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,

  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_req_type,
  input  logic signed [SAMPLE_BITS-1:0]            in_bin_re,
  input  logic signed [SAMPLE_BITS-1:0]            in_bin_im,
  input  logic                                     in_last_bin,
  input  logic [rpt_pkg::RD_IDX_W-1:0]             in_read_index,

  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     out_kind,
  output logic                                     out_target_found,
  output logic [rpt_pkg::PEAK_BIN_W-1:0]           out_peak_bin,
  output logic signed [ANGLE_BITS-1:0]             out_peak_phase,
  output logic signed [rpt_pkg::PHASE_W-1:0]       out_unwrapped_phase,
  output logic [$clog2(RING_DEPTH+1)-1:0]          out_samples_held,
  output logic                                     out_analysis_due,
  output logic signed [rpt_pkg::PHASE_W-1:0]       out_read_data,

  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [rpt_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [rpt_pkg::MAG_CFG_W-1:0]            cfg_data
);

  localparam int AW        = $clog2(RING_DEPTH);
  localparam int HW        = $clog2(RING_DEPTH + 1);
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int MAG_W     = 2 * SAMPLE_BITS;
  localparam int PW        = rpt_pkg::PHASE_W;
  localparam int TCMP_W    = (MAG_W > rpt_pkg::THR_W) ? MAG_W : rpt_pkg::THR_W;
  localparam int RW        = (AW > 8) ? AW + 2 : 10;
  localparam int RED_STEPS = (RING_DEPTH > 255) ? 0 : $clog2(256 / RING_DEPTH) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DRAIN  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_CORDIC = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_RDOUT  = 3'd6;

  localparam logic signed [ANGLE_BITS:0] HALF  = {2'b01, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [ANGLE_BITS:0] NHALF = {2'b11, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [PW-1:0]              FULL  = 32'd1 << ANGLE_BITS;
  localparam logic [PW-1:0]              RND   = 32'd1 << (31 - ANGLE_BITS);

  logic [2:0]                       state_r, state_nxt;
  logic [rpt_pkg::MIN_BIN_W-1:0]    min_bin_r;
  logic [rpt_pkg::MAG_CFG_W-1:0]    min_mag_r;
  logic [rpt_pkg::THR_W-1:0]        thr_r;

  logic [AW-1:0]                    wp_r;
  logic [HW-1:0]                    held_r, held_inc;
  logic signed [ANGLE_BITS-1:0]     prev_r, raw_r;
  logic [PW-1:0]                    off_r, off_nxt, unwr_r, unwr_nxt;
  logic                             target_r, rd_valid_r;

  logic                             out_valid_r;
  logic                             out_kind_r, out_found_r, out_due_r;
  logic [rpt_pkg::PEAK_BIN_W-1:0]   out_bin_r;
  logic signed [ANGLE_BITS-1:0]     out_raw_r;
  logic [PW-1:0]                    out_unwr_r, out_rdata_r;
  logic [HW-1:0]                    out_held_r;

  logic                             in_acc, bin_push, rd_acc, out_free, emit_frame, emit_read;
  logic                             peak_clear, target, cordic_start;
  logic [MAG_W-1:0]                 best_mag;
  logic [BIN_W-1:0]                 best_bin;
  logic signed [SAMPLE_BITS-1:0]    best_re, best_im;
  rpt_pkg::cordic_stat_t            cstat;
  logic [PW-1:0]                    rnd_turns;
  logic signed [ANGLE_BITS:0]       dp;
  logic [RW-1:0]                    red_v, pos_sum;
  logic [AW-1:0]                    rd_pos;
  logic                             rd_in_fill;
  logic [PW-1:0]                    ram_q;

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_valid && in_ready;
  assign bin_push   = in_acc && (in_req_type == rpt_pkg::REQ_BIN);
  assign rd_acc     = in_acc && (in_req_type == rpt_pkg::REQ_READ);
  assign out_free   = !out_valid_r || out_ready;
  assign emit_frame = (state_r == S_EMIT) && out_free;
  assign emit_read  = (state_r == S_RDOUT) && out_free;
  assign peak_clear = emit_frame;
  assign target     = TCMP_W'(best_mag) >= TCMP_W'(thr_r);
  assign cordic_start = (state_r == S_CHECK) && target;
  assign held_inc   = (held_r == HW'(RING_DEPTH)) ? held_r : held_r + 1'b1;

  rpt_peak #(
    .NUM_BINS    (NUM_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_peak (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (bin_push),
    .last     (in_last_bin),
    .re       (in_bin_re),
    .im       (in_bin_im),
    .min_bin  (min_bin_r),
    .clear    (peak_clear),
    .best_mag (best_mag),
    .best_bin (best_bin),
    .best_re  (best_re),
    .best_im  (best_im)
  );

  rpt_cordic #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .re    (best_re),
    .im    (best_im),
    .stat  (cstat)
  );

  rpt_ram #(
    .WIDTH (PW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (emit_frame && target_r),
    .waddr (wp_r),
    .wdata (unwr_r),
    .re    (rd_acc),
    .raddr (rd_pos),
    .rdata (ram_q)
  );

  // ring slot of read_index, oldest first once full: (wp + idx) mod depth
  always_comb begin
    red_v = RW'(in_read_index);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (red_v >= (RW'(RING_DEPTH) << k)) begin
        red_v = red_v - (RW'(RING_DEPTH) << k);
      end
    end
    pos_sum = red_v + RW'(wp_r);
    if (pos_sum >= RW'(RING_DEPTH)) begin
      pos_sum = pos_sum - RW'(RING_DEPTH);
    end
  end

  assign rd_pos     = pos_sum[AW-1:0];
  assign rd_in_fill = (held_r == HW'(RING_DEPTH)) || (rd_pos < wp_r);

  assign rnd_turns = cstat.turns + RND;
  assign dp        = {raw_r[ANGLE_BITS-1], raw_r} - {prev_r[ANGLE_BITS-1], prev_r};

  always_comb begin
    off_nxt = off_r;
    if (dp > HALF) begin
      off_nxt = off_r - FULL;
    end else if (dp < NHALF) begin
      off_nxt = off_r + FULL;
    end
    unwr_nxt = {{(PW-ANGLE_BITS){raw_r[ANGLE_BITS-1]}}, raw_r} + off_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (bin_push && in_last_bin) begin
          state_nxt = S_DRAIN;
        end else if (rd_acc) begin
          state_nxt = S_RDOUT;
        end
      end
      S_DRAIN:  state_nxt = S_CHECK;
      S_CHECK:  state_nxt = target ? S_CORDIC : S_EMIT;
      S_CORDIC: begin
        if (cstat.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDOUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_bin_r   <= 5'd11;
      min_mag_r   <= 23'd6291;
      wp_r        <= '0;
      held_r      <= '0;
      prev_r      <= '0;
      off_r       <= '0;
      target_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == rpt_pkg::CFG_MIN_BIN) begin
          min_bin_r <= cfg_data[rpt_pkg::MIN_BIN_W-1:0];
        end else if (cfg_index == rpt_pkg::CFG_MIN_MAG) begin
          min_mag_r <= cfg_data;
        end
      end
      if (state_r == S_CHECK) begin
        target_r <= target;
      end
      if (state_r == S_FINISH) begin
        prev_r <= raw_r;
        off_r  <= off_nxt;
      end
      if (emit_frame && target_r) begin
        wp_r   <= (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        held_r <= held_inc;
      end
      if (emit_frame || emit_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= rpt_pkg::THR_W'(min_mag_r) * rpt_pkg::THR_W'(min_mag_r);
    if (cstat.done) begin
      raw_r <= rnd_turns[31 -: ANGLE_BITS];
    end
    if (state_r == S_FINISH) begin
      unwr_r <= unwr_nxt;
    end
    if (rd_acc) begin
      rd_valid_r <= rd_in_fill;
    end
    if (emit_frame) begin
      out_kind_r  <= rpt_pkg::KIND_FRAME;
      out_found_r <= target_r;
      out_bin_r   <= rpt_pkg::PEAK_BIN_W'(best_bin);
      out_raw_r   <= target_r ? raw_r : '0;
      out_unwr_r  <= target_r ? unwr_r : '0;
      out_held_r  <= target_r ? held_inc : held_r;
      out_due_r   <= target_r && (held_inc == HW'(RING_DEPTH));
      out_rdata_r <= '0;
    end else if (emit_read) begin
      out_kind_r  <= rpt_pkg::KIND_READ;
      out_found_r <= 1'b0;
      out_bin_r   <= '0;
      out_raw_r   <= '0;
      out_unwr_r  <= '0;
      out_held_r  <= held_r;
      out_due_r   <= 1'b0;
      out_rdata_r <= rd_valid_r ? ram_q : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_target_found    = out_found_r;
  assign out_peak_bin        = out_bin_r;
  assign out_peak_phase      = out_raw_r;
  assign out_unwrapped_phase = out_unwr_r;
  assign out_samples_held    = out_held_r;
  assign out_analysis_due    = out_due_r;
  assign out_read_data       = out_rdata_r;

endmodule

FILE: rtl/rpt_ram.sv
module rpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rpt_peak.sv
module rpt_peak #(
  parameter int NUM_BINS    = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic                                 last,
  input  logic signed [SAMPLE_BITS-1:0]        re,
  input  logic signed [SAMPLE_BITS-1:0]        im,
  input  logic [rpt_pkg::MIN_BIN_W-1:0]        min_bin,
  input  logic                                 clear,
  output logic [2*SAMPLE_BITS-1:0]             best_mag,
  output logic [$clog2(NUM_BINS)-1:0]          best_bin,
  output logic signed [SAMPLE_BITS-1:0]        best_re,
  output logic signed [SAMPLE_BITS-1:0]        best_im
);

  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int MAG_W = 2 * SAMPLE_BITS;
  localparam int CMP_W = (CNT_W > rpt_pkg::MIN_BIN_W) ? CNT_W : rpt_pkg::MIN_BIN_W;

  logic [CNT_W-1:0]              cnt_r;
  logic                          searched;
  logic [SAMPLE_BITS-1:0]        abs_re, abs_im;

  logic                          s1_v_r;
  logic [BIN_W-1:0]              s1_bin_r;
  logic signed [SAMPLE_BITS-1:0] s1_re_r, s1_im_r;
  logic [MAG_W-1:0]              s1_sqr_r, s1_sqi_r;
  logic [MAG_W-1:0]              mag;

  logic [MAG_W-1:0]              best_mag_r;
  logic [BIN_W-1:0]              best_bin_r;
  logic signed [SAMPLE_BITS-1:0] best_re_r, best_im_r;

  assign searched = (cnt_r < CNT_W'(NUM_BINS)) && (CMP_W'(cnt_r) >= CMP_W'(min_bin));
  assign abs_re   = re[SAMPLE_BITS-1] ? (~re + 1'b1) : re;
  assign abs_im   = im[SAMPLE_BITS-1] ? (~im + 1'b1) : im;
  assign mag      = s1_sqr_r + s1_sqi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= push && searched;
      if (push) begin
        if (last) begin
          cnt_r <= '0;
        end else if (cnt_r < CNT_W'(NUM_BINS)) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_bin_r <= cnt_r[BIN_W-1:0];
    s1_re_r  <= re;
    s1_im_r  <= im;
    s1_sqr_r <= MAG_W'(abs_re) * MAG_W'(abs_re);
    s1_sqi_r <= MAG_W'(abs_im) * MAG_W'(abs_im);
  end

  // strictly larger wins, so the first of equal bins stays
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      best_mag_r <= '0;
      best_bin_r <= '0;
      best_re_r  <= '0;
      best_im_r  <= '0;
    end else if (s1_v_r && (mag > best_mag_r)) begin
      best_mag_r <= mag;
      best_bin_r <= s1_bin_r;
      best_re_r  <= s1_re_r;
      best_im_r  <= s1_im_r;
    end
  end

  assign best_mag = best_mag_r;
  assign best_bin = best_bin_r;
  assign best_re  = best_re_r;
  assign best_im  = best_im_r;

endmodule

FILE: rtl/rpt_cordic.sv
module rpt_cordic #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] re,
  input  logic signed [SAMPLE_BITS-1:0] im,
  output rpt_pkg::cordic_stat_t         stat
);

  localparam int CW    = rpt_pkg::CORDIC_W;
  localparam int IW    = rpt_pkg::CORDIC_IT_W;
  localparam int SHIFT = rpt_pkg::CORDIC_PRESCALE - SAMPLE_BITS;

  logic signed [CW-1:0] x0, y0, dx, dy;
  logic signed [CW-1:0] x_r, y_r;
  logic [31:0]          z_r;
  logic [IW-1:0]        it_r;
  logic                 busy_r, done_r, zero_r;

  assign x0 = {{(CW-SAMPLE_BITS){re[SAMPLE_BITS-1]}}, re} <<< SHIFT;
  assign y0 = {{(CW-SAMPLE_BITS){im[SAMPLE_BITS-1]}}, im} <<< SHIFT;
  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        if (it_r == IW'(rpt_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          it_r <= it_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (re == '0) && (im == '0);
      if (re[SAMPLE_BITS-1]) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= 32'h80000000;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (!y_r[CW-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + rpt_pkg::ATAN_TURNS[it_r];
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - rpt_pkg::ATAN_TURNS[it_r];
      end
    end
  end

  assign stat.done  = done_r;
  assign stat.turns = zero_r ? 32'd0 : z_r;

endmodule

FILE: tb/range_peak_phase_tracker_test.sv
module range_peak_phase_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BIN_SLOTS     = 32;
  localparam int RING          = 256;
  localparam int HALF_TURN     = 32768;
  localparam logic [31:0] FULL_TURN = 32'h0001_0000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PARK_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;
  localparam logic [rpt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [31:0] ATAN_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic               req;
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               last;
    logic [7:0]         ridx;
  } bin_item_t;

  typedef struct packed {
    logic               kind;
    logic               found;
    logic [4:0]         peak;
    logic signed [15:0] raw;
    logic signed [31:0] unwrapped;
    logic [8:0]         held;
    logic               due;
    logic signed [31:0] rdata;
  } report_t;

  typedef struct packed {
    logic                          is_reg;
    logic [rpt_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [22:0]                   reg_val;
    bin_item_t                     item;
    logic                          typed;
    report_t                       want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_req_type = 1'b0;
  logic signed [23:0] in_bin_re = '0;
  logic signed [23:0] in_bin_im = '0;
  logic               in_last_bin = 1'b0;
  logic [7:0]         in_read_index = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic               out_target_found;
  logic [4:0]         out_peak_bin;
  logic signed [15:0] out_peak_phase;
  logic signed [31:0] out_unwrapped_phase;
  logic [8:0]         out_samples_held;
  logic               out_analysis_due;
  logic signed [31:0] out_read_data;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [22:0]                   cfg_data = '0;

  range_peak_phase_tracker dut (.*);

  always #5 clk = ~clk;

  // tracker state
  logic [4:0]         cfg_first_bin = 5'd11;
  logic [22:0]        cfg_mag_floor = 23'd6291;
  int                 bins_seen = 0;
  longint             peak_mag = 0;
  logic [4:0]         peak_idx = '0;
  longint             peak_re = 0;
  longint             peak_im = 0;
  logic signed [15:0] last_raw = '0;
  logic [31:0]        turn_bias = '0;
  logic [7:0]         ring_wr = '0;
  logic [8:0]         ring_fill = '0;
  logic [31:0]        phase_hist [RING] = '{default: '0};

  report_t pending_reports [$];
  int      failures = 0;
  bit      sender_steady = 1'b0;
  bit      park_results = 1'b0;

  function automatic logic signed [15:0] bin_angle(input longint re, input longint im);
    longint      x, y, dx, dy;
    logic [31:0] z, rounded;
    x = re * 65536;
    y = im * 65536;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_STEP[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_STEP[i];
      end
    end
    rounded = z + 32'h0000_8000;
    return rounded[31:16];
  endfunction

  function automatic bit advance_tracker(input bin_item_t it, output report_t rep);
    longint             a, b, mag;
    logic signed [15:0] raw;
    logic [31:0]        unw;
    int                 dp;
    rep = '0;
    if (it.req == rpt_pkg::REQ_READ) begin
      rep.kind = rpt_pkg::KIND_READ;
      rep.held = ring_fill;
      rep.rdata = phase_hist[8'(ring_wr + it.ridx)];
      return 1'b1;
    end
    a = $signed(it.re);
    b = $signed(it.im);
    if (bins_seen < BIN_SLOTS && bins_seen >= int'(cfg_first_bin)) begin
      mag = a * a + b * b;
      if (mag > peak_mag) begin
        peak_mag = mag;
        peak_idx = 5'(bins_seen);
        peak_re = a;
        peak_im = b;
      end
    end
    if (bins_seen < BIN_SLOTS) bins_seen++;
    if (!it.last) return 1'b0;
    rep.kind = rpt_pkg::KIND_FRAME;
    rep.peak = peak_idx;
    if (peak_mag >= longint'(cfg_mag_floor) * longint'(cfg_mag_floor)) begin
      raw = bin_angle(peak_re, peak_im);
      dp = int'(raw) - int'(last_raw);
      if (dp > HALF_TURN) turn_bias -= FULL_TURN;
      else if (dp < -HALF_TURN) turn_bias += FULL_TURN;
      last_raw = raw;
      unw = turn_bias + 32'(int'(raw));
      phase_hist[ring_wr] = unw;
      ring_wr++;
      if (ring_fill < RING) ring_fill++;
      rep.found = 1'b1;
      rep.raw = raw;
      rep.unwrapped = unw;
      rep.due = (ring_fill == RING);
    end
    rep.held = ring_fill;
    bins_seen = 0;
    peak_mag = 0;
    peak_idx = '0;
    peak_re = 0;
    peak_im = 0;
    return 1'b1;
  endfunction

  function automatic logic signed [23:0] draw_component();
    logic signed [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 7))
      0, 1, 2: return v;
      3, 4: return 24'($signed($urandom_range(0, 8190)) - 4095);
      5: return v[0] ? 24'sh800000 : 24'sh7FFFFF;
      6: return '0;
      default: return v >>> $urandom_range(0, 22);
    endcase
  endfunction

  function automatic script_row_t bin_row(input logic signed [23:0] re,
                                          input logic signed [23:0] im, input logic last);
    script_row_t r;
    r = '0;
    r.item.req = rpt_pkg::REQ_BIN;
    r.item.re = re;
    r.item.im = im;
    r.item.last = last;
    return r;
  endfunction

  function automatic script_row_t read_row(input logic [7:0] ridx);
    script_row_t r;
    r = '0;
    r.item.req = rpt_pkg::REQ_READ;
    r.item.ridx = ridx;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [rpt_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [22:0] val);
    script_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic script_row_t checked(input script_row_t r, input report_t want);
    script_row_t o;
    o = r;
    o.typed = 1'b1;
    o.want = want;
    return o;
  endfunction

  // zero-phase frame report
  function automatic report_t frame_rep(input logic found, input logic [8:0] held);
    report_t w;
    w = '0;
    w.kind = rpt_pkg::KIND_FRAME;
    w.found = found;
    w.held = held;
    return w;
  endfunction

  function automatic report_t read_rep(input logic [8:0] held, input logic [31:0] data);
    report_t w;
    w = '0;
    w.kind = rpt_pkg::KIND_READ;
    w.held = held;
    w.rdata = data;
    return w;
  endfunction

  task automatic offer(input bin_item_t it, input bit typed, input report_t want);
    int      gap;
    report_t rep;
    if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req;
    in_bin_re <= it.re;
    in_bin_im <= it.im;
    in_last_bin <= it.last;
    in_read_index <= it.ridx;
    do @(posedge clk); while (!in_ready);
    if (advance_tracker(it, rep)) pending_reports.push_back(typed ? want : rep);
  endtask

  task automatic write_reg(input logic [rpt_pkg::CFG_IDX_W-1:0] idx, input logic [22:0] val,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rpt_pkg::CFG_MIN_BIN) cfg_first_bin = val[4:0];
    else if (idx == rpt_pkg::CFG_MIN_MAG) cfg_mag_floor = val;
    if (!hold) cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic match_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin : result_check
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result item, kind %0d", out_kind);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        match_field("kind", want.kind, out_kind);
        match_field("target_found", want.found, out_target_found);
        match_field("peak_bin", want.peak, out_peak_bin);
        match_field("peak_phase", $signed(want.raw), out_peak_phase);
        match_field("unwrapped_phase", $signed(want.unwrapped), out_unwrapped_phase);
        match_field("samples_held", want.held, out_samples_held);
        match_field("analysis_due", want.due, out_analysis_due);
        match_field("read_data", $signed(want.rdata), out_read_data);
      end
    end
  end

  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (park_results) begin
        park_results = 1'b0;
        out_ready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    script_row_t script [$];
    bin_item_t   it;
    int          len, sent;
    logic [4:0]  fb;
    logic [22:0] fm;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    script = '{
      checked(read_row(8'd0), read_rep(9'd0, 32'd0)),
      checked(read_row(8'd255), read_rep(9'd0, 32'd0)),
      checked(bin_row(24'sh7FFFFF, 24'sh7FFFFF, 1'b1), frame_rep(1'b0, 9'd0)),
      reg_row(rpt_pkg::CFG_MIN_BIN, 23'd0),
      checked(bin_row(24'sd0, 24'sd0, 1'b1), frame_rep(1'b0, 9'd0)),
      reg_row(rpt_pkg::CFG_MIN_MAG, 23'd0),
      checked(bin_row(24'sd0, 24'sd0, 1'b1), frame_rep(1'b1, 9'd1)),
      bin_row(24'sh800000, 24'sd0, 1'b0),
      bin_row(24'sd0, 24'sh800000, 1'b0),
      read_row(8'd255),
      bin_row(24'sh800000, 24'sh800000, 1'b1),
      bin_row(24'sh7FFFFF, -24'sd1, 1'b1),
      bin_row(24'sh800000, 24'sd1, 1'b1),
      bin_row(24'sh800000, -24'sd1, 1'b1),
      reg_row(rpt_pkg::CFG_MIN_MAG, 23'h7FFFFF),
      reg_row(CFG_SPARE, 23'h7FFFFF),
      bin_row(24'sh7FFFFF, 24'sh7FFFFF, 1'b1),
      checked(bin_row(24'sd100, -24'sd100, 1'b1), frame_rep(1'b0, 9'd6)),
      bin_row(24'sh7FFFFF, 24'sd0, 1'b1),
      reg_row(rpt_pkg::CFG_MIN_BIN, 23'd31),
      checked(bin_row(24'sd1, 24'sd1, 1'b1), frame_rep(1'b0, 9'd7)),
      read_row(8'd0),
      read_row(8'd249),
      read_row(8'd255)
    };

    foreach (script[r]) begin
      if (script[r].is_reg) begin
        settle();
        write_reg(script[r].reg_idx, script[r].reg_val, 1'b0);
      end else begin
        offer(script[r].item, script[r].typed, script[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          fb = 5'd0;
          fm = 23'd0;
        end
        PHASES - 1: begin
          fb = 5'd31;
          fm = 23'h7FFFFF;
        end
        default: begin
          fb = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd0;
          case ($urandom_range(0, 3))
            0: fm = 23'd0;
            1: fm = 23'($urandom_range(0, 8191));
            2: fm = 23'($urandom);
            default: fm = 23'($urandom) >> $urandom_range(0, 22);
          endcase
        end
      endcase
      write_reg(rpt_pkg::CFG_MIN_BIN, 23'(fb), 1'b1);
      write_reg(rpt_pkg::CFG_MIN_MAG, fm, 1'b0);
      if (ph == 2) park_results = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0: len = $urandom_range(17, 40);
          1, 2, 3, 4: len = $urandom_range(2, 16);
          default: len = 1;
        endcase
        for (int b = 0; b < len; b++) begin
          if ($urandom_range(0, 9) == 0) begin
            it.req = rpt_pkg::REQ_READ;
            it.re = draw_component();
            it.im = draw_component();
            it.last = 1'($urandom_range(0, 1));
            it.ridx = 8'($urandom_range(0, 255));
            offer(it, 1'b0, '0);
            sent++;
          end
          it.req = rpt_pkg::REQ_BIN;
          it.re = draw_component();
          it.im = draw_component();
          it.last = (b == len - 1);
          it.ridx = 8'($urandom_range(0, 255));
          offer(it, 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rpt_pkg.sv
rtl/rpt_ram.sv
rtl/rpt_peak.sv
rtl/rpt_cordic.sv
rtl/range_peak_phase_tracker.sv
tb/range_peak_phase_tracker_test.sv
